FILE: sv/rvag_pkg.sv
package rvag_pkg;

  localparam int unsigned StoreDepth = 6912;
  localparam int unsigned StoreAddrWidth = 13;

  localparam logic [1:0] CMD_TICK       = 2'd0;
  localparam logic [1:0] CMD_MEM_WRITE  = 2'd1;
  localparam logic [1:0] CMD_PORT_WRITE = 2'd2;

  localparam logic [15:0] STORE_BASE = 16'h4000;
  localparam logic [7:0]  LAST_COLUMN = 8'd223;
  localparam logic [8:0]  LAST_LINE = 9'd311;
  localparam logic [8:0]  FIRST_SHOWN_LINE = 9'd16;
  localparam logic [8:0]  DISPLAY_TOP = 9'd64;
  localparam logic [7:0]  SYNC_START = 8'd152;
  localparam logic [7:0]  SYNC_END = 8'd200;
  localparam logic [7:0]  STORE_RESET_BYTE = 8'hFF;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  data_value;
  } cmd_item_t;

  typedef struct packed {
    logic [3:0] pixel_left;
    logic [3:0] pixel_right;
    logic       frame_end;
  } pix_item_t;

  typedef struct packed {
    logic                      en;
    logic [StoreAddrWidth-1:0] addr;
    logic [7:0]                data;
  } mem_write_t;

  typedef struct packed {
    logic       display;
    logic [2:0] border;
    logic       flash;
    logic [1:0] phase;
    logic       frame_end;
  } tick_info_t;

endpackage

FILE: sv/raster_video_attribute_generator_unit.sv
// Raster attribute video source. Each cmd item is a beam tick, a write into the
// 6912-byte screen store or a border port write; a visible tick yields one pix item
// with two palette indices. One item is taken per clock while cmd_ready is high, and
// a tick's pixels pass first through the registered read of bitmap and
// attribute bytes from the two-read-port store, then through the output register, which
// also lets one more item in while a result waits. After reset the store is filled
// with all ones in one pass over its 6912 entries, during which cmd_ready stays low.
module raster_video_attribute_generator_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  rvag_pkg::cmd_item_t cmd,
  output logic                pix_valid,
  input  logic                pix_ready,
  output rvag_pkg::pix_item_t pix
);
  import rvag_pkg::*;

  logic                      accept;
  logic                      take;
  logic                      clearing;
  logic                      free;
  mem_write_t                wr;
  tick_info_t                info;
  logic [StoreAddrWidth-1:0] bmp_addr;
  logic [StoreAddrWidth-1:0] att_addr;
  logic [7:0]                bmp_data;
  logic [7:0]                att_data;

  assign cmd_ready = !clearing && free;
  assign accept = cmd_valid && cmd_ready;

  rvag_beam u_beam (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cmd      (cmd),
    .wr       (wr),
    .take     (take),
    .info     (info),
    .bmp_addr (bmp_addr),
    .att_addr (att_addr)
  );

  rvag_screen_ram u_ram (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .rd_en     (take),
    .rd_addr_a (bmp_addr),
    .rd_addr_b (att_addr),
    .rd_data_a (bmp_data),
    .rd_data_b (att_data),
    .clearing  (clearing)
  );

  rvag_pixel u_pixel (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .info      (info),
    .bmp_data  (bmp_data),
    .att_data  (att_data),
    .free      (free),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix)
  );

endmodule

FILE: sv/rvag_screen_ram.sv
module rvag_screen_ram (
  input  logic                                clk,
  input  logic                                rst,
  input  rvag_pkg::mem_write_t                wr,
  input  logic                                rd_en,
  input  logic [rvag_pkg::StoreAddrWidth-1:0] rd_addr_a,
  input  logic [rvag_pkg::StoreAddrWidth-1:0] rd_addr_b,
  output logic [7:0]                          rd_data_a,
  output logic [7:0]                          rd_data_b,
  output logic                                clearing
);
  import rvag_pkg::*;

  localparam logic [StoreAddrWidth-1:0] LastEntry = StoreAddrWidth'(StoreDepth - 1);

  logic [7:0] store [StoreDepth];
  logic [StoreAddrWidth-1:0] clear_addr;
  logic [StoreAddrWidth-1:0] waddr;
  logic [7:0] wdata;
  logic wen;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == LastEntry) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clearing) begin
      wen = 1'b1;
      waddr = clear_addr;
      wdata = STORE_RESET_BYTE;
    end else begin
      wen = wr.en;
      waddr = wr.addr;
      wdata = wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= store[rd_addr_a];
      rd_data_b <= store[rd_addr_b];
    end
  end

endmodule

FILE: sv/rvag_beam.sv
module rvag_beam (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  rvag_pkg::cmd_item_t                 cmd,
  output rvag_pkg::mem_write_t                wr,
  output logic                                take,
  output rvag_pkg::tick_info_t                info,
  output logic [rvag_pkg::StoreAddrWidth-1:0] bmp_addr,
  output logic [rvag_pkg::StoreAddrWidth-1:0] att_addr
);
  import rvag_pkg::*;

  logic [7:0] column;
  logic [8:0] line;
  logic [2:0] border;
  logic [4:0] frame_count;
  logic       flash;
  logic [7:0] column_next;
  logic [8:0] line_next;
  logic [4:0] frame_count_next;
  logic       tick;
  logic       visible;
  logic [8:0] row_full;
  logic [7:0] row;
  logic [4:0] char_col;
  logic       in_store;
  logic [15:0] offset;

  assign tick = accept && (cmd.command == CMD_TICK);
  assign visible = (line >= FIRST_SHOWN_LINE) && !((column >= SYNC_START) && (column < SYNC_END));
  assign take = tick && visible;

  assign row_full = line - DISPLAY_TOP;
  assign row = row_full[7:0];
  assign char_col = column[6:2];
  assign bmp_addr = {row[7:6], row[2:0], row[5:3], char_col};
  assign att_addr = {3'b110, row[7:3], char_col};

  assign info.display = !column[7] && !line[8] && (line[7:6] != 2'b00);
  assign info.border = border;
  assign info.flash = flash;
  assign info.phase = column[1:0];
  assign info.frame_end = (column == LAST_COLUMN) && (line == LAST_LINE);

  assign offset = cmd.address - STORE_BASE;
  assign in_store = (cmd.address >= STORE_BASE) && (offset < 16'(StoreDepth));
  assign wr.en = accept && (cmd.command == CMD_MEM_WRITE) && in_store;
  assign wr.addr = offset[StoreAddrWidth-1:0];
  assign wr.data = cmd.data_value;

  always_comb begin
    column_next = column + 1'b1;
    line_next = line;
    frame_count_next = frame_count;
    if (column >= LAST_COLUMN) begin
      column_next = '0;
      if (line >= LAST_LINE) begin
        line_next = '0;
        frame_count_next = frame_count + 1'b1;
      end else begin
        line_next = line + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      line <= '0;
      frame_count <= '0;
      flash <= 1'b1;
      border <= '0;
    end else begin
      if (tick) begin
        column <= column_next;
        line <= line_next;
        frame_count <= frame_count_next;
        if (frame_count_next != frame_count) begin
          flash <= frame_count_next[4];
        end
      end
      if (accept && (cmd.command == CMD_PORT_WRITE) && !cmd.address[0]) begin
        border <= cmd.data_value[2:0];
      end
    end
  end

endmodule

FILE: sv/rvag_pixel.sv
module rvag_pixel (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  rvag_pkg::tick_info_t info,
  input  logic [7:0]           bmp_data,
  input  logic [7:0]           att_data,
  output logic                 free,
  output logic                 pix_valid,
  input  logic                 pix_ready,
  output rvag_pkg::pix_item_t  pix
);
  import rvag_pkg::*;

  logic       stage_valid;
  tick_info_t stage_info;
  logic       out_load;
  logic [3:0] ink;
  logic [3:0] paper;
  logic [3:0] fore;
  logic [3:0] back;
  pix_item_t  pix_next;

  assign out_load = !pix_valid || pix_ready;
  assign free = !stage_valid || out_load;

  always_comb begin
    ink = {att_data[6], att_data[2:0]};
    paper = {att_data[6], att_data[5:3]};
    if (att_data[7] && stage_info.flash) begin
      fore = paper;
      back = ink;
    end else begin
      fore = ink;
      back = paper;
    end
    pix_next.frame_end = stage_info.frame_end;
    if (stage_info.display) begin
      pix_next.pixel_left = bmp_data[{~stage_info.phase, 1'b1}] ? fore : back;
      pix_next.pixel_right = bmp_data[{~stage_info.phase, 1'b0}] ? fore : back;
    end else begin
      pix_next.pixel_left = {1'b0, stage_info.border};
      pix_next.pixel_right = {1'b0, stage_info.border};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      pix_valid <= 1'b0;
    end else begin
      if (take) begin
        stage_valid <= 1'b1;
      end else if (out_load) begin
        stage_valid <= 1'b0;
      end
      if (out_load) begin
        pix_valid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_info <= info;
    end
    if (out_load) begin
      pix <= pix_next;
    end
  end

endmodule

FILE: sv/rvag_checker.sv
module rvag_checker (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_ready,
  input rvag_pkg::cmd_item_t cmd,
  input logic                pix_valid,
  input logic                pix_ready,
  input rvag_pkg::pix_item_t pix
);
  import rvag_pkg::*;

  a_ready_low_after_reset: assert property (@(posedge clk) rst |=> !cmd_ready)
    else $error("Block took items right after reset.");

  a_pix_held: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid && $stable(pix))
    else $error("Stalled pix item changed or vanished.");

  a_same_bright: assert property (@(posedge clk) disable iff (rst)
    pix_valid |-> pix.pixel_left[3] == pix.pixel_right[3])
    else $error("Pixels of one item differ in brightness.");

  a_frame_end_border: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix.frame_end |->
      pix.pixel_left == pix.pixel_right && !pix.pixel_left[3])
    else $error("Last position of the frame is not a border item.");

endmodule

bind raster_video_attribute_generator_unit rvag_checker u_rvag_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd),
  .pix_valid (pix_valid),
  .pix_ready (pix_ready),
  .pix       (pix)
);
